### rtl/line_sensor_threshold_calibrator_assert.svh
// assertion macros for the line sensor threshold calibrator
`ifndef LINE_SENSOR_THRESHOLD_CALIBRATOR_ASSERT_SVH
`define LINE_SENSOR_THRESHOLD_CALIBRATOR_ASSERT_SVH

// condition holds at every clock edge out of reset
`define LSTC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define LSTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LSTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/lstc_pkg.sv
// shared constants for the line sensor threshold calibrator
`default_nettype none

package lstc_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 16;
    localparam int CNT_W    = 6;
    localparam int ACC_W    = 22;

    // register reset value
    localparam logic [THR_W-1:0] LIMIT_RESET = 16'd16384;

    // default block sizing
    localparam int SENSORS_DEF = 7;
    localparam int FRAMES_DEF  = 50;

endpackage

`default_nettype wire

### rtl/lstc_const_div.sv
// unsigned division by an elaboration-time constant through a rounded-up reciprocal
`default_nettype none

module lstc_const_div #(
    parameter int DIVISOR = 6,
    parameter int IN_W    = 19,
    parameter int OUT_W   = 16
) (
    input  wire logic [IN_W-1:0]  i_dividend,
    output logic      [OUT_W-1:0] o_quotient
);

    // m = ceil(2^(N+l) / d) with l = ceil(log2 d) is exact for every N-bit dividend
    localparam int    Lg    = $clog2(DIVISOR);
    localparam int    Shift = IN_W + Lg;
    localparam int    MulW  = IN_W + 1;
    localparam int    ProdW = IN_W + MulW + OUT_W;
    localparam longint MulFull = ((longint'(1) << Shift) + longint'(DIVISOR) - 1)
                                 / longint'(DIVISOR);
    localparam logic [MulW-1:0] Mul = MulW'(MulFull);

    logic [ProdW-1:0] prod;

    // single multiply, quotient taken from the high bits
    assign prod       = ProdW'(i_dividend) * ProdW'(Mul);
    assign o_quotient = prod[Shift +: OUT_W];

endmodule

`default_nettype wire

### rtl/line_sensor_threshold_calibrator.sv
// top level of the line sensor threshold calibrator
`default_nettype none

// Takes one discharge-time sample per cycle, SENSORS samples per frame. The
// largest sample of a frame is black, the mean of the others is white, and the
// frame threshold is the truncated midpoint. Frames with 0 < threshold <
// valid_limit are accumulated; when FRAMES of them are counted the result
// carries done_res and the truncated average, and the accumulator restarts.
// Every completed frame gives exactly one result transaction after its last
// sample is taken. A new sample is taken every cycle while the result side
// keeps up; the four-register result pipeline (frame totals, white divide,
// threshold and accumulate, average divide) backs up under i_stall and
// stalls input only once it is full. The user must write valid_limit through
// i_cfg_we and i_cfg_data only while no frame is in flight; not enforced here.
`include "line_sensor_threshold_calibrator_assert.svh"

module line_sensor_threshold_calibrator #(
    parameter int SENSORS = lstc_pkg::SENSORS_DEF,
    parameter int FRAMES  = lstc_pkg::FRAMES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration
    input  wire logic                          i_cfg_we,
    input  wire logic [lstc_pkg::THR_W-1:0]    i_cfg_data,
    // sample channel
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [lstc_pkg::SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [lstc_pkg::THR_W-1:0]    o_frame_threshold,
    output logic                               o_frame_valid,
    output logic      [lstc_pkg::CNT_W-1:0]    o_valid_count,
    output logic                               o_done_res,
    output logic      [lstc_pkg::THR_W-1:0]    o_calibrated
);

    import lstc_pkg::*;

    localparam int PosW = $clog2(SENSORS);
    localparam int SumW = SAMPLE_W + $clog2(SENSORS);
    localparam logic [PosW-1:0]  LastPos  = PosW'(SENSORS - 1);
    localparam logic [CNT_W-1:0] FrameCnt = CNT_W'(FRAMES);

    // configuration register
    logic [THR_W-1:0] r_valid_limit;

    // frame gathering state
    logic [PosW-1:0]     r_pos;
    logic [SAMPLE_W-1:0] r_max;
    logic [SumW-1:0]     r_sum;

    // frame totals stage
    logic                r_f_vld;
    logic [SAMPLE_W-1:0] r_f_max;
    logic [SumW-1:0]     r_f_sum;

    // black and white stage
    logic                r_t_vld;
    logic [SAMPLE_W-1:0] r_t_max;
    logic [THR_W-1:0]    r_t_white;

    // threshold stage and running accumulation
    logic                r_a_vld;
    logic [THR_W-1:0]    r_a_thr;
    logic                r_a_valid;
    logic [CNT_W-1:0]    r_a_cnt;
    logic                r_a_done;
    logic [ACC_W-1:0]    r_a_acc;
    logic [ACC_W-1:0]    r_acc;
    logic [CNT_W-1:0]    r_cnt;

    // output register
    logic                r_o_vld;
    logic [THR_W-1:0]    r_o_thr;
    logic                r_o_valid;
    logic [CNT_W-1:0]    r_o_cnt;
    logic                r_o_done;
    logic [THR_W-1:0]    r_o_cal;

    logic                rdy_o, rdy_a, rdy_t, rdy_f;
    logic                in_acc, frame_end, ge;
    logic [SAMPLE_W-1:0] n_max;
    logic [SumW-1:0]     n_sum;
    logic [THR_W-1:0]    white, thr, avg;
    logic                thr_ok, done;
    logic [CNT_W-1:0]    cnt_inc, n_cnt;
    logic [ACC_W-1:0]    n_acc;

    // stage readiness, back to front
    assign rdy_o   = !r_o_vld || !i_stall;
    assign rdy_a   = !r_a_vld || rdy_o;
    assign rdy_t   = !r_t_vld || rdy_a;
    assign rdy_f   = !r_f_vld || rdy_t;
    assign o_stall = !rdy_f;
    assign in_acc  = i_valid && !o_stall;

    // running max and sum of the others
    assign ge        = i_sample >= r_max;
    assign n_max     = ge ? i_sample : r_max;
    assign n_sum     = r_sum + SumW'(ge ? r_max : i_sample);
    assign frame_end = r_pos == LastPos;

    // white is the mean of the non-maximum samples
    lstc_const_div #(
        .DIVISOR (SENSORS - 1),
        .IN_W    (SumW),
        .OUT_W   (THR_W)
    ) u_white_div (
        .i_dividend (r_f_sum),
        .o_quotient (white)
    );

    // midpoint threshold, validity and accumulation
    assign thr     = r_t_white + ((r_t_max - r_t_white) >> 1);
    assign thr_ok  = (thr != '0) && (thr < r_valid_limit);
    assign cnt_inc = r_cnt + CNT_W'(1);
    assign n_cnt   = thr_ok ? cnt_inc : r_cnt;
    assign done    = thr_ok && (cnt_inc >= FrameCnt);
    assign n_acc   = r_acc + ACC_W'(thr);

    // average of the accumulated thresholds
    lstc_const_div #(
        .DIVISOR (FRAMES),
        .IN_W    (ACC_W),
        .OUT_W   (THR_W)
    ) u_avg_div (
        .i_dividend (r_a_acc),
        .o_quotient (avg)
    );

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_limit <= LIMIT_RESET;
            r_pos         <= '0;
            r_max         <= '0;
            r_sum         <= '0;
            r_f_vld       <= 1'b0;
            r_t_vld       <= 1'b0;
            r_a_vld       <= 1'b0;
            r_o_vld       <= 1'b0;
            r_acc         <= '0;
            r_cnt         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_valid_limit <= i_cfg_data;
            end
            if (in_acc) begin
                if (frame_end) begin
                    r_pos <= '0;
                    r_max <= '0;
                    r_sum <= '0;
                end else begin
                    r_pos <= r_pos + PosW'(1);
                    r_max <= n_max;
                    r_sum <= n_sum;
                end
            end
            if (rdy_f) begin
                r_f_vld <= in_acc && frame_end;
            end
            if (rdy_t) begin
                r_t_vld <= r_f_vld;
            end
            if (rdy_a) begin
                r_a_vld <= r_t_vld;
            end
            if (rdy_o) begin
                r_o_vld <= r_a_vld;
            end
            if (rdy_a && r_t_vld) begin
                if (done) begin
                    r_acc <= '0;
                    r_cnt <= '0;
                end else if (thr_ok) begin
                    r_acc <= n_acc;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (in_acc && frame_end) begin
            r_f_max <= n_max;
            r_f_sum <= n_sum;
        end
        if (rdy_t && r_f_vld) begin
            r_t_max   <= r_f_max;
            r_t_white <= white;
        end
        if (rdy_a && r_t_vld) begin
            r_a_thr   <= thr;
            r_a_valid <= thr_ok;
            r_a_cnt   <= n_cnt;
            r_a_done  <= done;
            r_a_acc   <= thr_ok ? n_acc : r_acc;
        end
        if (rdy_o && r_a_vld) begin
            r_o_thr   <= r_a_thr;
            r_o_valid <= r_a_valid;
            r_o_cnt   <= r_a_cnt;
            r_o_done  <= r_a_done;
            r_o_cal   <= r_a_done ? avg : '0;
        end
    end

    // result ports
    assign o_valid           = r_o_vld;
    assign o_frame_threshold = r_o_thr;
    assign o_frame_valid     = r_o_valid;
    assign o_valid_count     = r_o_cnt;
    assign o_done_res        = r_o_done;
    assign o_calibrated      = r_o_cal;

    // checks
    `LSTC_ASSERT_ALWAYS(a_pos_range, r_pos <= LastPos, "frame position out of range")
    `LSTC_ASSERT_NEXT(a_frame_restart, in_acc && frame_end, r_pos == '0 && r_sum == '0,
        "frame gathering did not restart")
    `LSTC_ASSERT_SAME(a_done_count, r_o_vld && r_o_done, r_o_valid && r_o_cnt == FrameCnt,
        "done result without a full valid count")
    `LSTC_ASSERT_SAME(a_cal_zero, r_o_vld && !r_o_done, r_o_cal == '0,
        "average given on a result without done")
    `LSTC_ASSERT_SAME(a_cnt_range, 1'b1, r_cnt < FrameCnt,
        "valid frame count reached its limit without clearing")

endmodule

`default_nettype wire
